// ===== sv/bmds_pkg.sv =====
package bmds_pkg;

    localparam int unsigned Q_DEPTH = 2;

    // Register block offsets
    localparam logic [5:0] OFF_DIV_CTL_LO  = 6'd0;
    localparam logic [5:0] OFF_DIV_CTL_HI  = 6'd1;
    localparam logic [5:0] OFF_SQRT_CTL_LO = 6'd48;
    localparam logic [5:0] OFF_SQRT_CTL_HI = 6'd49;
    localparam logic [2:0] BANK_NUMER      = 3'd2;
    localparam logic [2:0] BANK_DENOM      = 3'd3;
    localparam logic [2:0] BANK_QUOT       = 3'd4;
    localparam logic [2:0] BANK_REM        = 3'd5;
    localparam logic [2:0] BANK_RADICAND   = 3'd7;
    localparam logic [3:0] ROOT_WORD       = 4'd13;

    localparam logic [1:0] MODE_32_32 = 2'd0;
    localparam logic [1:0] MODE_64_64 = 2'd2;

    localparam logic [5:0] DIV_STEPS_M1  = 6'd63;
    localparam logic [5:0] SQRT64_STEPS_M1 = 6'd31;
    localparam logic [5:0] SQRT32_STEPS_M1 = 6'd15;

    typedef enum logic [1:0] {
        K_READ,
        K_WRITE_DIV,
        K_WRITE_SQRT,
        K_WRITE_NONE
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [5:0] offset;
        logic [7:0] data;
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_INIT,
        ST_DIV_RUN,
        ST_DIV_FIX,
        ST_SQ_INIT,
        ST_SQ_RUN
    } t_state;

    function automatic logic [63:0] sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

// ===== sv/bmds_in_if.sv =====
interface bmds_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [5:0] byte_offset;
    logic [7:0] write_byte;

    modport source (output valid, command, byte_offset, write_byte, input ready);
    modport sink   (input valid, command, byte_offset, write_byte, output ready);
endinterface

// ===== sv/bmds_out_if.sv =====
interface bmds_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;

    modport source (output valid, read_byte, input ready);
    modport sink   (input valid, read_byte, output ready);
endinterface

// ===== sv/bmds_front.sv =====
module bmds_front
    import bmds_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = Q_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bmds_in_if.sink      i_req,
    output logic         o_q_valid,
    output t_req         o_q_req,
    input  logic         i_q_pop
);
    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_req           r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    t_req           w_req;
    logic           w_push;

    // classify: reads, writes that start a divide or a root, all other writes
    always_comb begin
        w_req.offset = i_req.byte_offset;
        w_req.data   = i_req.write_byte;
        if (!i_req.command) begin
            w_req.kind = K_READ;
        end else if (i_req.byte_offset == OFF_DIV_CTL_LO
                     || i_req.byte_offset[5:3] == BANK_NUMER
                     || i_req.byte_offset[5:3] == BANK_DENOM) begin
            w_req.kind = K_WRITE_DIV;
        end else if (i_req.byte_offset == OFF_SQRT_CTL_LO
                     || i_req.byte_offset[5:3] == BANK_RADICAND) begin
            w_req.kind = K_WRITE_SQRT;
        end else begin
            w_req.kind = K_WRITE_NONE;
        end
    end

    assign i_req.ready = (r_count != CW'(QUEUE_DEPTH));
    assign w_push      = i_req.valid && i_req.ready;
    assign o_q_valid   = (r_count != '0);
    assign o_q_req     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CW'(w_push) - CW'(i_q_pop);
        end
    end
endmodule

// ===== sv/bmds_back.sv =====
module bmds_back
    import bmds_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    input  t_req         i_q_req,
    output logic         o_q_pop,
    bmds_out_if.source   o_rsp
);
    t_state r_state, n_state;

    logic [7:0]  r_div_ctl;
    logic        r_zero;
    logic [63:0] r_numer, r_denom, r_quot, r_rem, r_radicand;
    logic [7:0]  r_sqrt_ctl;
    logic [31:0] r_root;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;

    // divider working registers
    logic [63:0] r_dq, r_drem, r_dad;
    logic        r_nneg, r_qneg;
    logic [5:0]  r_cnt;

    // root working registers
    logic [63:0] r_sval;
    logic [35:0] r_srem;
    logic [31:0] r_sres;

    logic        w_out_free, w_take, w_last, w_finish;
    logic [63:0] w_n, w_d;
    logic [64:0] w_dsh;
    logic        w_dge;
    logic [35:0] w_ssh;
    logic [33:0] w_trial;
    logic        w_sge;
    logic [7:0]  w_rd;

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_last     = (r_cnt == '0);

    // state machine: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid && w_out_free) begin
                    if (i_q_req.kind == K_WRITE_DIV) begin
                        n_state = ST_DIV_INIT;
                    end else if (i_q_req.kind == K_WRITE_SQRT) begin
                        n_state = ST_SQ_INIT;
                    end
                end
            end
            ST_DIV_INIT: begin
                if (w_d != '0 && !(r_div_ctl[1:0] == MODE_32_32
                        && w_n == 64'hFFFF_FFFF_8000_0000 && w_d == '1)) begin
                    n_state = ST_DIV_RUN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV_RUN:  n_state = w_last ? ST_DIV_FIX : ST_DIV_RUN;
            ST_DIV_FIX:  n_state = ST_IDLE;
            ST_SQ_INIT:  n_state = ST_SQ_RUN;
            ST_SQ_RUN:   n_state = w_last ? ST_IDLE : ST_SQ_RUN;
            default:     n_state = ST_IDLE;
        endcase
    end

    // state machine: outputs
    always_comb begin
        w_take   = 1'b0;
        w_finish = 1'b0;
        unique case (r_state)
            ST_IDLE:     w_take = i_q_valid && w_out_free;
            ST_DIV_INIT: w_finish = (n_state == ST_IDLE);
            ST_DIV_RUN:  w_finish = 1'b0;
            ST_DIV_FIX:  w_finish = 1'b1;
            ST_SQ_INIT:  w_finish = 1'b0;
            ST_SQ_RUN:   w_finish = w_last;
            default:     w_finish = 1'b0;
        endcase
    end

    assign o_q_pop         = w_take;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_byte = r_out_byte;

    // operand selection for the divide
    assign w_n = (r_div_ctl[1:0] == MODE_32_32) ? sext32(r_numer[31:0]) : r_numer;
    assign w_d = (r_div_ctl[1:0] == MODE_64_64) ? r_denom : sext32(r_denom[31:0]);

    assign w_dsh = {r_drem, r_dq[63]};
    assign w_dge = (w_dsh >= {1'b0, r_dad});

    assign w_ssh   = {r_srem[33:0], r_sval[63:62]};
    assign w_trial = {r_sres, 2'b01};
    assign w_sge   = (w_ssh >= {2'b00, w_trial});

    // read mux
    always_comb begin
        w_rd = '0;
        if (i_q_req.offset == OFF_DIV_CTL_LO) begin
            w_rd = r_div_ctl;
        end else if (i_q_req.offset == OFF_DIV_CTL_HI) begin
            w_rd = {1'b0, r_zero, 6'b0};
        end else if (i_q_req.offset == OFF_SQRT_CTL_LO) begin
            w_rd = r_sqrt_ctl;
        end else if (i_q_req.offset == OFF_SQRT_CTL_HI) begin
            w_rd = '0;
        end else if (i_q_req.offset[5:2] == ROOT_WORD) begin
            w_rd = r_root[8*i_q_req.offset[1:0] +: 8];
        end else begin
            case (i_q_req.offset[5:3])
                BANK_NUMER:    w_rd = r_numer[8*i_q_req.offset[2:0] +: 8];
                BANK_DENOM:    w_rd = r_denom[8*i_q_req.offset[2:0] +: 8];
                BANK_QUOT:     w_rd = r_quot[8*i_q_req.offset[2:0] +: 8];
                BANK_REM:      w_rd = r_rem[8*i_q_req.offset[2:0] +: 8];
                BANK_RADICAND: w_rd = r_radicand[8*i_q_req.offset[2:0] +: 8];
                default:       w_rd = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_div_ctl   <= '0;
            r_zero      <= 1'b0;
            r_numer     <= '0;
            r_denom     <= '0;
            r_quot      <= '0;
            r_rem       <= '0;
            r_sqrt_ctl  <= '0;
            r_radicand  <= '0;
            r_root      <= '0;
        end else begin
            r_state <= n_state;
            // raise on a read or ignored write taken, or an engine done; drop when taken
            if ((w_take && (i_q_req.kind == K_READ || i_q_req.kind == K_WRITE_NONE))
                    || w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_take) begin
                r_out_byte <= (i_q_req.kind == K_READ) ? w_rd : 8'h00;
                if (i_q_req.kind == K_WRITE_DIV) begin
                    if (i_q_req.offset == OFF_DIV_CTL_LO) begin
                        r_div_ctl <= i_q_req.data;
                    end else if (i_q_req.offset[5:3] == BANK_NUMER) begin
                        r_numer[8*i_q_req.offset[2:0] +: 8] <= i_q_req.data;
                    end else begin
                        r_denom[8*i_q_req.offset[2:0] +: 8] <= i_q_req.data;
                    end
                end
                if (i_q_req.kind == K_WRITE_SQRT) begin
                    if (i_q_req.offset == OFF_SQRT_CTL_LO) begin
                        r_sqrt_ctl <= i_q_req.data;
                    end else begin
                        r_radicand[8*i_q_req.offset[2:0] +: 8] <= i_q_req.data;
                    end
                end
            end

            case (r_state)
                ST_DIV_INIT: begin
                    r_zero <= (r_denom == '0);
                    if (w_d == '0) begin
                        if (r_div_ctl[1:0] == MODE_32_32) begin
                            r_quot <= w_n[63] ? 64'hFFFF_FFFF_0000_0001
                                              : 64'h0000_0000_FFFF_FFFF;
                        end else begin
                            r_quot <= w_n[63] ? 64'd1 : '1;
                        end
                        r_rem <= w_n;
                    end else if (n_state == ST_IDLE) begin
                        // 32-bit overflow: clamp, hold remainder
                        r_quot <= 64'h0000_0000_8000_0000;
                    end
                    r_nneg <= w_n[63];
                    r_qneg <= w_n[63] ^ w_d[63];
                    r_dq   <= w_n[63] ? (64'd0 - w_n) : w_n;
                    r_dad  <= w_d[63] ? (64'd0 - w_d) : w_d;
                    r_drem <= '0;
                    r_cnt  <= DIV_STEPS_M1;
                end
                ST_DIV_RUN: begin
                    r_drem <= w_dge ? 64'(w_dsh - {1'b0, r_dad}) : w_dsh[63:0];
                    r_dq   <= {r_dq[62:0], w_dge};
                    r_cnt  <= r_cnt - 1'b1;
                end
                ST_DIV_FIX: begin
                    r_quot <= r_qneg ? (64'd0 - r_dq) : r_dq;
                    r_rem  <= r_nneg ? (64'd0 - r_drem) : r_drem;
                end
                ST_SQ_INIT: begin
                    r_sval <= r_sqrt_ctl[0] ? r_radicand : {r_radicand[31:0], 32'd0};
                    r_cnt  <= r_sqrt_ctl[0] ? SQRT64_STEPS_M1 : SQRT32_STEPS_M1;
                    r_srem <= '0;
                    r_sres <= '0;
                end
                ST_SQ_RUN: begin
                    r_srem <= w_sge ? (w_ssh - {2'b00, w_trial}) : w_ssh;
                    r_sres <= {r_sres[30:0], w_sge};
                    r_sval <= {r_sval[61:0], 2'b00};
                    r_cnt  <= r_cnt - 1'b1;
                    if (w_last) begin
                        r_root <= {r_sres[30:0], w_sge};
                    end
                end
                default: begin
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_q_pop)
        else $error("queue popped while engine busy");
    a_fix_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_FIX) |=> r_out_valid)
        else $error("divide finished without a response");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_finish || o_q_pop) |-> (!r_out_valid || o_rsp.ready))
        else $error("response register overwritten");
    a_sq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQ_RUN) |-> (r_cnt <= SQRT64_STEPS_M1))
        else $error("root step count out of range");
`endif
endmodule

// ===== sv/byte_mapped_divider_and_square_root_unit.sv =====
// Byte-mapped signed divider and integer square root. Each input item is one
// byte access (command 0 read, 1 write) to a 64-byte register block: divide
// control at 0..1, numerator 16..23, denominator 24..31, quotient 32..39,
// remainder 40..47, root control 48..49, root 52..55, radicand 56..63, all
// little endian; every item returns one read_byte item (zero for writes and
// unmapped offsets). A write that restarts the divide (control low byte,
// numerator, denominator) goes through take, setup, one radix-2 restoring
// step per cycle over 64 bits, and sign fixup; a zero divisor or the 32-bit
// overflow finishes right after setup. A write that restarts the root
// (control low byte, radicand) yields one result bit per cycle. A small queue
// in front lets the caller post further items while a long operation runs.
module byte_mapped_divider_and_square_root_unit
    import bmds_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = Q_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bmds_in_if.sink     i_req,
    bmds_out_if.source  o_rsp
);
    logic w_q_valid;
    t_req w_q_req;
    logic w_q_pop;

    // accept and classify items, hold them in the queue
    bmds_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_q_valid (w_q_valid),
        .o_q_req   (w_q_req),
        .i_q_pop   (w_q_pop)
    );

    // register file, divide and root engines, response register
    bmds_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_req   (w_q_req),
        .o_q_pop   (w_q_pop),
        .o_rsp     (o_rsp)
    );
endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import bmds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;
    localparam logic [15:0] DIV_ZERO_BIT  = 16'h4000;
    localparam logic [15:0] BUSY_BIT      = 16'h8000;
    localparam logic [63:0] INT32_MIN_EXT = 64'hFFFF_FFFF_8000_0000;

    // Shadow of the register block. Every access queues the byte that the
    // block must return for it.
    class math_unit_shadow;
        logic [15:0] div_ctl;
        logic [63:0] numer, denom, quot, remd, radicand;
        logic [15:0] sqrt_ctl;
        logic [31:0] root;
        logic [7:0]  read_bytes[$];
        int          mismatches;

        function new();
            div_ctl = '0; numer = '0; denom = '0; quot = '0; remd = '0;
            sqrt_ctl = '0; radicand = '0; root = '0;
            mismatches = 0;
        endfunction

        function automatic logic [63:0] sx(input logic [63:0] v);
            return {{32{v[31]}}, v[31:0]};
        endfunction

        // Truncating signed divide on 64-bit patterns, nonzero divisor.
        function automatic void signed_divide(input logic [63:0] n, input logic [63:0] d);
            logic [63:0] an, ad, uq, ur;
            an = n[63] ? -n : n;
            ad = d[63] ? -d : d;
            uq = an / ad;
            ur = an % ad;
            quot = (n[63] != d[63]) ? -uq : uq;
            remd = n[63] ? -ur : ur;
        endfunction

        function automatic void divide();
            logic [63:0] n, d;
            div_ctl &= ~(DIV_ZERO_BIT | BUSY_BIT);
            if (div_ctl[1:0] == MODE_32_32) begin
                n = sx(numer);
                d = sx(denom);
                if (d == '0) begin
                    quot = n[63] ? 64'hFFFF_FFFF_0000_0001 : 64'h0000_0000_FFFF_FFFF;
                    remd = n;
                end else if (n == INT32_MIN_EXT && d == '1) begin
                    // clamp the 32-bit overflow, remainder stays as it was
                    quot = 64'h0000_0000_8000_0000;
                end else begin
                    signed_divide(n, d);
                end
            end else begin
                n = numer;
                d = (div_ctl[1:0] == MODE_64_64) ? denom : sx(denom);
                if (d == '0) begin
                    quot = n[63] ? 64'd1 : '1;
                    remd = n;
                end else begin
                    signed_divide(n, d);
                end
            end
            if (denom == '0) div_ctl |= DIV_ZERO_BIT;
        endfunction

        function automatic void square_root();
            logic [63:0] val, acc, res, trial;
            int steps;
            sqrt_ctl &= ~BUSY_BIT;
            val = sqrt_ctl[0] ? radicand : {32'd0, radicand[31:0]};
            steps = sqrt_ctl[0] ? 32 : 16;
            if (!sqrt_ctl[0]) val = val << 32;
            acc = '0;
            res = '0;
            for (int i = 0; i < steps; i++) begin
                acc = (acc << 2) + val[63:62];
                val = val << 2;
                res = res << 1;
                trial = (res << 1) + 1;
                if (acc >= trial) begin
                    acc -= trial;
                    res++;
                end
            end
            root = res[31:0];
        endfunction

        function automatic void note_access(input logic cmd, input logic [5:0] off,
                                            input logic [7:0] wb);
            logic [7:0] rb;
            logic [2:0] bank;
            logic [5:0] sh;
            rb = '0;
            bank = off[5:3];
            sh = {off[2:0], 3'b000};
            if (cmd == CMD_READ) begin
                if (off == OFF_DIV_CTL_LO) rb = div_ctl[7:0];
                else if (off == OFF_DIV_CTL_HI) rb = div_ctl[15:8];
                else if (bank == BANK_NUMER) rb = numer[sh +: 8];
                else if (bank == BANK_DENOM) rb = denom[sh +: 8];
                else if (bank == BANK_QUOT) rb = quot[sh +: 8];
                else if (bank == BANK_REM) rb = remd[sh +: 8];
                else if (off == OFF_SQRT_CTL_LO) rb = sqrt_ctl[7:0];
                else if (off == OFF_SQRT_CTL_HI) rb = sqrt_ctl[15:8];
                else if (off[5:2] == ROOT_WORD) rb = root[{off[1:0], 3'b000} +: 8];
                else if (bank == BANK_RADICAND) rb = radicand[sh +: 8];
            end else begin
                if (off == OFF_DIV_CTL_LO) begin
                    div_ctl[7:0] = wb;
                    divide();
                end else if (bank == BANK_NUMER) begin
                    numer[sh +: 8] = wb;
                    divide();
                end else if (bank == BANK_DENOM) begin
                    denom[sh +: 8] = wb;
                    divide();
                end else if (off == OFF_SQRT_CTL_LO) begin
                    sqrt_ctl[7:0] = wb;
                    square_root();
                end else if (bank == BANK_RADICAND) begin
                    radicand[sh +: 8] = wb;
                    square_root();
                end
            end
            read_bytes.push_back(rb);
        endfunction

        task report(input string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_byte(input logic [7:0] got);
            logic [7:0] want;
            if (read_bytes.size() == 0) begin
                report($sformatf("unexpected read_byte %02h", got));
            end else begin
                want = read_bytes.pop_front();
                if (got !== want)
                    report($sformatf("read_byte %02h, want %02h", got, want));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    bmds_in_if  u_req ();
    bmds_out_if u_rsp ();

    byte_mapped_divider_and_square_root_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req.sink),
        .o_rsp   (u_rsp.source)
    );

    math_unit_shadow shadow = new();
    int  rx_hold;       // cycles the receiver must still hold off
    bit  rx_quiet;      // no random stalls on the receiver side
    bit  timed_out;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Receiver: honor a requested hold-off first, then stall at random.
    initial begin
        u_rsp.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold > 0) begin
                u_rsp.ready <= 1'b0;
                rx_hold--;
            end else if (rx_quiet) begin
                u_rsp.ready <= 1'b1;
            end else begin
                u_rsp.ready <= (gap_len() == 0);
            end
            @(posedge i_clk);
            if (u_rsp.valid && u_rsp.ready) shadow.check_byte(u_rsp.read_byte);
        end
    end

    // Offer one item and hold it until the block takes it.
    task put_item(input logic cmd, input logic [5:0] off, input logic [7:0] wb);
        u_req.valid       <= 1'b1;
        u_req.command     <= cmd;
        u_req.byte_offset <= off;
        u_req.write_byte  <= wb;
        do @(posedge i_clk); while (!u_req.ready);
        shadow.note_access(cmd, off, wb);
    endtask

    task idle_sender(input int n);
        if (n > 0) begin
            u_req.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task drain();
        u_req.valid <= 1'b0;
        while (shadow.read_bytes.size() != 0) @(posedge i_clk);
    endtask

    // Load a full 64-bit register, little endian, starting at base.
    task load_word(input logic [5:0] base, input logic [63:0] v);
        for (int i = 0; i < 8; i++) begin
            put_item(CMD_WRITE, base + 6'(i), v[i*8 +: 8]);
            idle_sender(gap_len());
        end
    endtask

    task read_results();
        for (int i = 0; i < 16; i++) begin
            put_item(CMD_READ, {BANK_QUOT, 3'd0} + 6'(i), 8'($urandom));
            idle_sender(gap_len());
        end
        put_item(CMD_READ, OFF_DIV_CTL_LO, 8'h00);
        put_item(CMD_READ, OFF_DIV_CTL_HI, 8'h00);
    endtask

    function automatic logic [7:0] spicy_byte();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    task random_access();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            put_item(CMD_WRITE, {BANK_NUMER, 3'($urandom)}, spicy_byte());
        else if (r < 60)
            put_item(CMD_WRITE, {BANK_DENOM, 3'($urandom)}, spicy_byte());
        else if (r < 65)
            put_item(CMD_WRITE, OFF_DIV_CTL_LO, 8'($urandom));
        else if (r < 72)
            put_item(CMD_WRITE, {BANK_RADICAND, 3'($urandom)}, spicy_byte());
        else if (r < 75)
            put_item(CMD_WRITE, OFF_SQRT_CTL_LO, 8'($urandom));
        else if (r < 93)
            put_item(CMD_READ, 6'($urandom), 8'($urandom));
        else
            put_item(1'($urandom), 6'($urandom), 8'($urandom));
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        u_req.valid       <= 1'b0;
        u_req.command     <= CMD_READ;
        u_req.byte_offset <= '0;
        u_req.write_byte  <= '0;
        rx_hold  = 0;
        rx_quiet = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset values, zero divisor in modes 0 and 1, overflow, roots.
        put_item(CMD_READ, OFF_DIV_CTL_LO, 8'h00);
        put_item(CMD_WRITE, OFF_DIV_CTL_LO, {6'd0, MODE_32_32});
        load_word({BANK_NUMER, 3'd0}, 64'h0000_0000_8000_0000);
        read_results();
        load_word({BANK_DENOM, 3'd0}, 64'hFFFF_FFFF_FFFF_FFFF);
        read_results();
        put_item(CMD_WRITE, OFF_DIV_CTL_LO, 8'h03);
        load_word({BANK_NUMER, 3'd0}, 64'h8000_0000_0000_0000);
        put_item(CMD_WRITE, OFF_DIV_CTL_LO, {6'd0, MODE_64_64});
        read_results();
        load_word({BANK_DENOM, 3'd0}, 64'h0000_0001_0000_0000);
        read_results();
        put_item(CMD_WRITE, OFF_DIV_CTL_LO, 8'h01);
        read_results();
        load_word({BANK_DENOM, 3'd0}, 64'h0);
        read_results();
        put_item(CMD_WRITE, OFF_DIV_CTL_LO, 8'h00);
        read_results();
        // ignored writes to read-only and unmapped offsets
        put_item(CMD_WRITE, OFF_DIV_CTL_HI, 8'hFF);
        put_item(CMD_WRITE, {BANK_QUOT, 3'd3}, 8'hA5);
        put_item(CMD_WRITE, 6'd9, 8'h5A);
        put_item(CMD_WRITE, OFF_SQRT_CTL_HI, 8'hFF);
        put_item(CMD_WRITE, {ROOT_WORD, 2'd1}, 8'h77);
        load_word({BANK_RADICAND, 3'd0}, 64'hFFFF_FFFF_FFFF_FFFF);
        put_item(CMD_WRITE, OFF_SQRT_CTL_LO, 8'hFF);
        for (int i = 0; i < 4; i++) put_item(CMD_READ, {ROOT_WORD, 2'(i)}, 8'h00);
        put_item(CMD_WRITE, OFF_SQRT_CTL_LO, 8'h00);
        for (int i = 0; i < 4; i++) put_item(CMD_READ, {ROOT_WORD, 2'(i)}, 8'h00);
        drain();

        // Random traffic with one long receiver hold-off and one full drain.
        for (int k = 0; k < 955; k++) begin
            if (k == 300) rx_hold = 400;
            if (k == 600) drain();
            rx_quiet = (k >= 800 && k < 900);
            random_access();
            if (k < 300 || k > 320) idle_sender(gap_len());
        end
        u_req.valid <= 1'b0;

        while (shadow.read_bytes.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (shadow.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        timed_out = 1'b0;
        #40ms;
        timed_out = 1'b1;
        $display("FAILURE");
        $finish;
    end

endmodule
